/* src/alw_pkg.sv */
// package for the polyline arc-length weight unit
// shared payload structs, queue entry, back-end state enum and defaults
// no dependencies
package alw_pkg;

    localparam int FRAC_BITS_DEF    = 16;
    localparam int LENGTH_WIDTH_DEF = 40;
    localparam int QUEUE_DEPTH_DEF  = 4;
    localparam int LEN_MAX_W        = 48;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic               line_start;
        logic               set_start;
        logic [39:0]        line_length;
        logic [15:0]        cp_count;
    } alw_in_t;

    typedef struct packed {
        logic [47:0] alpha_weight;
        logic        degenerate;
    } alw_out_t;

    // one classified vertex handed from front to back
    typedef struct packed {
        logic [31:0]          dx;
        logic [31:0]          dy;
        logic [31:0]          dz;
        logic                 first;
        logic [31:0]          offset;
        logic [15:0]          span;
        logic [LEN_MAX_W-1:0] len;
    } alw_job_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_SQ,
        B_ROOT,
        B_RUN,
        B_MUL,
        B_DIV,
        B_OUT
    } alw_bstate_t;

endpackage

/* src/alw_front.sv */
// front end: accepts vertices, tracks line context and forms distance jobs
// depends on alw_pkg
module alw_front #(
    parameter int LENGTH_WIDTH = alw_pkg::LENGTH_WIDTH_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  alw_pkg::alw_in_t s_data,
    input  logic             q_full,
    output logic             q_push,
    output alw_pkg::alw_job_t q_job
);
    import alw_pkg::*;

    logic [31:0]             prev_x_reg, prev_y_reg, prev_z_reg;
    logic [31:0]             offset_reg, offset_next;
    logic [15:0]             count_reg;
    logic [LENGTH_WIDTH-1:0] len_reg, len_in;
    logic [LEN_MAX_W-1:0]    len_wide;
    logic [15:0]             span;

    function automatic logic [31:0] mag_diff(input logic [31:0] a, input logic [31:0] b);
        logic signed [32:0] d;
        logic signed [32:0] m;
        d = $signed({a[31], a}) - $signed({b[31], b});
        m = d[32] ? -d : d;
        return m[31:0];
    endfunction

    assign s_ready = !q_full;
    assign q_push  = s_valid && s_ready;

    assign len_wide = LEN_MAX_W'(s_data.line_length);
    assign len_in   = len_wide[LENGTH_WIDTH-1:0];

    always_comb begin
        offset_next = s_data.set_start ? 32'd0 : offset_reg + {16'd0, count_reg};
    end

    assign span = (count_reg >= 16'd1) ? count_reg - 16'd1 : 16'd0;

    always_comb begin
        q_job.dx     = mag_diff(s_data.pos_x, prev_x_reg);
        q_job.dy     = mag_diff(s_data.pos_y, prev_y_reg);
        q_job.dz     = mag_diff(s_data.pos_z, prev_z_reg);
        q_job.first  = s_data.line_start;
        q_job.offset = s_data.line_start ? offset_next : offset_reg;
        q_job.span   = span;
        q_job.len    = LEN_MAX_W'(len_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_x_reg <= '0;
            prev_y_reg <= '0;
            prev_z_reg <= '0;
            offset_reg <= '0;
            count_reg  <= '0;
            len_reg    <= '0;
        end else if (q_push) begin
            prev_x_reg <= s_data.pos_x;
            prev_y_reg <= s_data.pos_y;
            prev_z_reg <= s_data.pos_z;
            if (s_data.line_start) begin
                offset_reg <= offset_next;
                count_reg  <= s_data.cp_count;
                len_reg    <= len_in;
            end
        end
    end

endmodule

/* src/alw_queue.sv */
// short job queue between front and back ends
// depends on alw_pkg
module alw_queue #(
    parameter int DEPTH = alw_pkg::QUEUE_DEPTH_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  alw_pkg::alw_job_t push_job,
    output logic              full,
    input  logic              pop,
    output logic              empty,
    output alw_pkg::alw_job_t pop_job
);
    import alw_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    alw_job_t        slot_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]   fill_reg;

    assign full    = (fill_reg == CW'(DEPTH));
    assign empty   = (fill_reg == '0);
    assign pop_job = slot_reg[rd_ptr_reg];

    function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (push) wr_ptr_reg <= bump(wr_ptr_reg);
            if (pop)  rd_ptr_reg <= bump(rd_ptr_reg);
            if (push && !pop)      fill_reg <= fill_reg + CW'(1);
            else if (pop && !push) fill_reg <= fill_reg - CW'(1);
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn) full |-> !push)
        else $error("queue written while full");
    assert property (@(posedge aclk) disable iff (!aresetn) empty |-> !pop)
        else $error("queue read while empty");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> (fill_reg == $past(fill_reg) + CW'(1)))
        else $error("fill count lost a write");

endmodule

/* src/alw_back.sv */
// back end: distance, running length, ratio division and output register
// depends on alw_pkg
module alw_back #(
    parameter int FRAC_BITS    = alw_pkg::FRAC_BITS_DEF,
    parameter int LENGTH_WIDTH = alw_pkg::LENGTH_WIDTH_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_empty,
    output logic              q_pop,
    input  alw_pkg::alw_job_t q_job,
    output logic              m_valid,
    input  logic              m_ready,
    output alw_pkg::alw_out_t m_data
);
    import alw_pkg::*;

    localparam int LW  = LENGTH_WIDTH;
    localparam int FW  = 16 + FRAC_BITS;           // fraction width
    localparam int NUMW = LW + 16;                 // run * span
    localparam int NW  = NUMW + FRAC_BITS;         // dividend bits
    localparam int DCW = $clog2(NW + 1);
    localparam int AW  = 32 + FRAC_BITS + 1;
    localparam longint EPS = ((64'd1 << FRAC_BITS) + 64'd9999) / 64'd10000;
    localparam int ROOT_STEPS = 33;

    alw_bstate_t state_reg, state_next;

    alw_job_t          job_reg;
    logic [1:0]        sq_idx_reg;
    logic [65:0]       sum_reg;
    logic [63:0]       prod;
    logic [31:0]       sq_sel;
    logic [35:0]       rem_reg;
    logic [35:0]       rem_try;
    logic [35:0]       trial;
    logic [33:0]       root_reg;
    logic [5:0]        root_cnt_reg;
    logic [LW-1:0]     run_reg;
    logic [LW:0]       run_sum;
    logic [LW-1:0]     run_sat;
    logic [LW-1:0]     len;
    logic [NW-1:0]     dvd_reg;
    logic [LW:0]       drem_reg;
    logic [LW:0]       drem_try;
    logic              drem_ge;
    logic [FW-1:0]     quo_reg;
    logic [FW-1:0]     quo_last;
    logic [DCW-1:0]    div_cnt_reg;
    logic [FW-1:0]     full_span;
    logic [FW-1:0]     clamp;
    logic [FW-1:0]     frac_reg;
    logic              deg_reg;
    logic [AW-1:0]     alpha;
    logic              out_valid_reg;
    alw_out_t          out_reg;
    logic              out_load;
    logic              run_big;

    assign len       = job_reg.len[LW-1:0];
    assign full_span = FW'(job_reg.span) << FRAC_BITS;
    assign clamp     = (full_span > FW'(EPS)) ? full_span - FW'(EPS) : '0;

    always_comb begin
        case (sq_idx_reg)
            2'd0:    sq_sel = job_reg.dx;
            2'd1:    sq_sel = job_reg.dy;
            default: sq_sel = job_reg.dz;
        endcase
    end
    assign prod = sq_sel * sq_sel;

    // two bits of the square sum per step
    assign rem_try = {rem_reg[33:0], sum_reg[65:64]};
    assign trial   = {root_reg, 2'b01};

    assign run_sum = {1'b0, run_reg} + (LW + 1)'(root_reg);
    assign run_sat = run_sum[LW] ? {LW{1'b1}} : run_sum[LW-1:0];
    assign run_big = (run_sat >= len);

    assign drem_try = {drem_reg[LW-1:0], dvd_reg[NW-1]};
    assign drem_ge  = (drem_try >= {1'b0, len});
    assign quo_last = {quo_reg[FW-2:0], drem_ge};

    assign alpha = (AW'(job_reg.offset) << FRAC_BITS) + AW'(frac_reg);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE: if (!q_empty) state_next = B_SQ;
            B_SQ:   if (sq_idx_reg == 2'd2) state_next = B_ROOT;
            B_ROOT: if (root_cnt_reg == 6'(ROOT_STEPS - 1)) state_next = B_RUN;
            B_RUN: begin
                if (job_reg.first || len == '0 || run_big) state_next = B_OUT;
                else                                         state_next = B_MUL;
            end
            B_MUL:  state_next = B_DIV;
            B_DIV:  if (div_cnt_reg == DCW'(NW - 1)) state_next = B_OUT;
            B_OUT:  if (out_load) state_next = B_IDLE;
            default: state_next = B_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        q_pop    = 1'b0;
        out_load = 1'b0;
        unique case (state_reg)
            B_IDLE:  q_pop    = !q_empty;
            B_OUT:   out_load = !out_valid_reg || m_ready;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= B_IDLE;
            run_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (out_load)              out_valid_reg <= 1'b1;
            else if (m_ready)          out_valid_reg <= 1'b0;
            if (state_reg == B_RUN)    run_reg <= job_reg.first ? '0 : run_sat;
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            B_IDLE: begin
                job_reg    <= q_job;
                sq_idx_reg <= '0;
                sum_reg    <= '0;
            end
            B_SQ: begin
                sum_reg      <= sum_reg + 66'(prod);
                sq_idx_reg   <= sq_idx_reg + 2'd1;
                rem_reg      <= '0;
                root_reg     <= '0;
                root_cnt_reg <= '0;
            end
            B_ROOT: begin
                if (rem_try >= trial) begin
                    rem_reg  <= rem_try - trial;
                    root_reg <= {root_reg[32:0], 1'b1};
                end else begin
                    rem_reg  <= rem_try;
                    root_reg <= {root_reg[32:0], 1'b0};
                end
                sum_reg      <= {sum_reg[63:0], 2'b00};
                root_cnt_reg <= root_cnt_reg + 6'd1;
            end
            B_RUN: begin
                if (job_reg.first) begin
                    deg_reg  <= 1'b0;
                    frac_reg <= '0;
                end else if (len == '0) begin
                    deg_reg  <= 1'b1;
                    frac_reg <= clamp;
                end else begin
                    deg_reg  <= 1'b0;
                    frac_reg <= clamp;
                end
            end
            B_MUL: begin
                dvd_reg     <= {NUMW'(run_reg) * NUMW'(job_reg.span), {FRAC_BITS{1'b0}}};
                drem_reg    <= '0;
                quo_reg     <= '0;
                div_cnt_reg <= '0;
            end
            B_DIV: begin
                if (drem_ge) begin
                    drem_reg <= drem_try - {1'b0, len};
                    quo_reg  <= {quo_reg[FW-2:0], 1'b1};
                end else begin
                    drem_reg <= drem_try;
                    quo_reg  <= {quo_reg[FW-2:0], 1'b0};
                end
                dvd_reg     <= {dvd_reg[NW-2:0], 1'b0};
                div_cnt_reg <= div_cnt_reg + DCW'(1);
                // last division step lands the quotient, clamped
                if (div_cnt_reg == DCW'(NW - 1)) begin
                    frac_reg <= (quo_last < clamp) ? quo_last : clamp;
                end
            end
            B_OUT: begin
                if (out_load) begin
                    out_reg.alpha_weight <= (alpha > AW'(48'hFFFF_FFFF_FFFF))
                                            ? 48'hFFFF_FFFF_FFFF : 48'(alpha);
                    out_reg.degenerate   <= deg_reg;
                end
            end
            default: ;
        endcase
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == B_DIV) |-> (drem_reg < {1'b0, len}))
        else $error("division remainder out of range");
    assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> (state_reg == B_IDLE && !q_empty))
        else $error("job taken outside idle");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == B_OUT) |-> (frac_reg <= full_span))
        else $error("fraction above span");
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> m_valid)
        else $error("result lost at output register");

endmodule

/* src/polyline_arc_length_weight_unit.sv */
// Polyline arc-length weight unit, top level.
// Depends on alw_pkg, alw_front, alw_queue and alw_back.
//
// Usage: vertices enter on s_valid/s_ready/s_data, one weight per vertex
// leaves on m_valid/m_ready/m_data in the same order. The front end takes a
// vertex whenever the job queue has room and records the line context; the
// back end works through one job at a time.
// Work per vertex in the back end: a line's first vertex passes through
// 3 squaring steps on one 32x32 multiplier, 33 square-root steps, the
// run update and the output; a later vertex adds one multiply step and
// LENGTH_WIDTH + 16 + FRAC_BITS restoring-division steps. A later vertex
// on a zero-length line, or whose run has reached the line length, skips
// the multiply and the division. The square root and divider are serial.
// A result waits in the output register while m_ready is low; the back end
// then holds, and the queue keeps taking vertices until it is full.
// Reset (aresetn low, synchronous) empties the queue, drops any pending
// result and clears previous vertex, offset, count, length and run.
module polyline_arc_length_weight_unit #(
    parameter int FRAC_BITS    = alw_pkg::FRAC_BITS_DEF,
    parameter int LENGTH_WIDTH = alw_pkg::LENGTH_WIDTH_DEF,
    parameter int QUEUE_DEPTH  = alw_pkg::QUEUE_DEPTH_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  alw_pkg::alw_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output alw_pkg::alw_out_t m_data
);
    import alw_pkg::*;

    alw_job_t push_job, pop_job;
    logic     push, pop, full, empty;

    alw_front #(.LENGTH_WIDTH(LENGTH_WIDTH)) u_front (
        .aclk, .aresetn, .s_valid, .s_ready, .s_data,
        .q_full(full), .q_push(push), .q_job(push_job)
    );

    alw_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .aclk, .aresetn, .push, .push_job, .full, .pop, .empty, .pop_job
    );

    alw_back #(.FRAC_BITS(FRAC_BITS), .LENGTH_WIDTH(LENGTH_WIDTH)) u_back (
        .aclk, .aresetn, .q_empty(empty), .q_pop(pop), .q_job(pop_job),
        .m_valid, .m_ready, .m_data
    );

endmodule

/* verif/polyline_arc_length_weight_unit_tb.sv */
`timescale 1ns / 100ps
// testbench for the polyline arc-length weight unit
// depends on alw_pkg and polyline_arc_length_weight_unit; self-checking, no files
module polyline_arc_length_weight_unit_tb;
    import alw_pkg::*;

    localparam int FRAC_BITS    = FRAC_BITS_DEF;
    localparam int LENGTH_WIDTH = LENGTH_WIDTH_DEF;
    localparam int WATCHDOG_MAX = 20000;
    localparam longint unsigned LEN_MASK = (64'd1 << LENGTH_WIDTH) - 1;
    localparam longint unsigned WEIGHT_MAX = (64'd1 << 48) - 1;
    localparam longint unsigned EPS_LSB = ((64'd1 << FRAC_BITS) + 9999) / 10000;

    logic     aclk;
    logic     aresetn;
    logic     s_valid;
    logic     s_ready;
    alw_in_t  s_data;
    logic     m_valid;
    logic     m_ready;
    alw_out_t m_data;

    // predictor state
    logic [31:0]     last_x, last_y, last_z;
    longint unsigned run_len;
    logic [31:0]     ctrl_offset;
    logic [15:0]     line_cp;
    longint unsigned line_len;

    alw_out_t weight_q[$];
    int       mismatches;
    int       idle_cycles;
    bit       sending_done;

    polyline_arc_length_weight_unit DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        aclk = 1'b0;
        #6;
        aclk = 1'b1;
        #6;
    end

    function automatic longint unsigned abs_delta(logic [31:0] a, logic [31:0] b);
        logic signed [32:0] d;
        d = $signed({a[31], a}) - $signed({b[31], b});
        return d < 0 ? longint'(-d) : longint'(d);
    endfunction

    // floor of the euclidean norm, bitwise root over a 128-bit sum
    function automatic longint unsigned vertex_distance(longint unsigned dx,
            longint unsigned dy, longint unsigned dz);
        logic [127:0]    sum;
        logic [127:0]    cand;
        longint unsigned root;
        sum  = 128'(dx) * dx + 128'(dy) * dy + 128'(dz) * dz;
        root = 0;
        for (int b = 33; b >= 0; b--) begin
            cand = 128'(root | (64'd1 << b));
            if (cand * cand <= sum) root = root | (64'd1 << b);
        end
        return root;
    endfunction

    function automatic alw_out_t predict_weight(alw_in_t v);
        alw_out_t        r;
        longint unsigned span, full, clamp, frac, step_len, q;
        logic [127:0]    num;
        frac = 0;
        r.degenerate = 1'b0;
        if (v.line_start) begin
            ctrl_offset = v.set_start ? 32'd0 : ctrl_offset + 32'(line_cp);
            line_cp  = v.cp_count;
            line_len = longint'(v.line_length) & LEN_MASK;
            run_len  = 0;
        end else begin
            step_len = vertex_distance(abs_delta(v.pos_x, last_x),
                                       abs_delta(v.pos_y, last_y),
                                       abs_delta(v.pos_z, last_z));
            span  = line_cp >= 1 ? longint'(line_cp) - 1 : 0;
            full  = span << FRAC_BITS;
            clamp = full > EPS_LSB ? full - EPS_LSB : 0;
            run_len = run_len + step_len;
            if (run_len > LEN_MASK) run_len = LEN_MASK;
            if (line_len == 0) begin
                frac = clamp;
                r.degenerate = 1'b1;
            end else if (run_len >= line_len) begin
                frac = clamp;
            end else begin
                num = (128'(run_len) * span) << FRAC_BITS;
                q = longint'(num / line_len);
                frac = q < clamp ? q : clamp;
            end
        end
        last_x = v.pos_x;
        last_y = v.pos_y;
        last_z = v.pos_z;
        q = (longint'(ctrl_offset) << FRAC_BITS) + frac;
        r.alpha_weight = 48'(q > WEIGHT_MAX ? WEIGHT_MAX : q);
        return r;
    endfunction

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // send one vertex, holding valid until the transaction completes
    // valid drops only across a gap, so back to back vertices keep it high
    task automatic send_vertex(alw_in_t v);
        int gap;
        gap = gap_len();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_data  <= v;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        weight_q = {weight_q, predict_weight(v)};
        @(negedge aclk);
    endtask

    function automatic alw_in_t make_vertex(logic ls, logic ss, logic [39:0] len,
            logic [15:0] cp, logic [31:0] x, logic [31:0] y, logic [31:0] z);
        alw_in_t v;
        v.pos_x = x;
        v.pos_y = y;
        v.pos_z = z;
        v.line_start = ls;
        v.set_start = ss;
        v.line_length = len;
        v.cp_count = cp;
        return v;
    endfunction

    function automatic logic [31:0] rand_coord(int mode);
        case (mode)
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 8'hff) << 12) - 32'sh80000);
            default: return 32'($urandom_range(0, 20'hfffff)) - 32'h80000;
        endcase
    endfunction

    task automatic test_directed();
        // vertices before any line start see zero length and count
        send_vertex(make_vertex(0, 1, 40'h123, 16'd9, 32'h0001_0000, 0, 0));
        send_vertex(make_vertex(0, 0, 40'h0, 16'd0, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff));
        send_vertex(make_vertex(1, 1, 40'h5_0000, 16'd4, 0, 0, 0));
        send_vertex(make_vertex(0, 0, 0, 0, 32'h1_0000, 0, 0));
        send_vertex(make_vertex(0, 0, 0, 0, 32'h1_0000, 32'h2_0000, 32'h2_0000));
        send_vertex(make_vertex(0, 0, 0, 0, 32'h1_0000, 32'h2_0000, 32'h2_0000));
        send_vertex(make_vertex(0, 0, 0, 0, 32'h9_0000, 32'h2_0000, 32'h2_0000));
        // zero length line, cp below two, then widest fields
        send_vertex(make_vertex(1, 0, 40'h0, 16'd2, 0, 0, 0));
        send_vertex(make_vertex(0, 0, 0, 0, 32'h10, 0, 0));
        send_vertex(make_vertex(1, 0, 40'h1_0000, 16'd1, 0, 0, 0));
        send_vertex(make_vertex(0, 0, 0, 0, 32'h100, 0, 0));
        send_vertex(make_vertex(1, 0, 40'h1_0000, 16'd0, 0, 0, 0));
        send_vertex(make_vertex(0, 1, 0, 0, 32'h100, 0, 0));
        send_vertex(make_vertex(1, 0, 40'hff_ffff_ffff, 16'hffff,
                                32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
        send_vertex(make_vertex(0, 0, 40'hff_ffff_ffff, 16'hffff,
                                32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));
        send_vertex(make_vertex(0, 0, 0, 0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
        send_vertex(make_vertex(0, 0, 0, 0, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));
        send_vertex(make_vertex(1, 0, 40'h1, 16'hffff, 0, 0, 0));
        send_vertex(make_vertex(0, 0, 0, 0, 0, 0, 0));
        send_vertex(make_vertex(0, 0, 0, 0, 32'hffff_ffff, 0, 0));
    endtask

    // offset accumulation toward saturation of the 48-bit weight
    task automatic test_offset_wrap();
        for (int i = 0; i < 40; i++)
            send_vertex(make_vertex(1, i == 0, 40'h1_0000, 16'hffff, 0, 0, 0));
        send_vertex(make_vertex(0, 0, 0, 0, 32'h8000, 0, 0));
    endtask

    task automatic test_random_lines();
        int sent;
        int nvert;
        int mode;
        logic [39:0] len;
        sent = 0;
        while (sent < 1150) begin
            if ($urandom_range(0, 9) == 0) begin
                // noise: lone vertex with random everything
                send_vertex(make_vertex(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                            {$urandom(), 8'($urandom())}, 16'($urandom()),
                            $urandom(), $urandom(), $urandom()));
                sent++;
                continue;
            end
            mode  = $urandom_range(0, 2);
            nvert = $urandom_range(1, 12);
            case ($urandom_range(0, 4))
                0: len = {$urandom(), 8'($urandom())};
                1: len = 0;
                default: len = 40'($urandom_range(1, 32'h00ff_ffff)) << $urandom_range(0, 6);
            endcase
            send_vertex(make_vertex(1, $urandom_range(0, 3) == 0, len,
                        $urandom_range(0, 3) == 0 ? 16'($urandom()) : 16'($urandom_range(0, 9)),
                        rand_coord(mode), rand_coord(mode), rand_coord(mode)));
            sent++;
            for (int k = 0; k < nvert; k++) begin
                send_vertex(make_vertex(0, 1'($urandom_range(0, 1)),
                            {$urandom(), 8'($urandom())},
                            16'($urandom()), rand_coord(mode), rand_coord(mode),
                            rand_coord(mode)));
                sent++;
            end
        end
    endtask

    // result side: random stalls, checked at the rising edge
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if ($urandom_range(0, 99) < 70 || sending_done) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b0;
                repeat (gap_len() + 1) @(negedge aclk);
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (weight_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected weight %h", m_data);
            end else if (m_data !== weight_q[0]) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: weight exp %h got %h, degenerate exp %b got %b",
                             weight_q[0].alpha_weight, m_data.alpha_weight,
                             weight_q[0].degenerate, m_data.degenerate);
                void'(weight_q.pop_front());
            end else begin
                void'(weight_q.pop_front());
            end
        end
    end

    // watchdog on cycles with no transaction on either side
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_MAX) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        mismatches   = 0;
        idle_cycles  = 0;
        sending_done = 0;
        s_valid      = 1'b0;
        s_data       = '0;
        aresetn      = 1'b0;
        last_x = 0; last_y = 0; last_z = 0;
        run_len = 0; ctrl_offset = 0; line_cp = 0; line_len = 0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_offset_wrap();
        test_random_lines();
        s_valid <= 1'b0;
        sending_done = 1;
        while (weight_q.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
